FILE: src/fjs_pkg.sv
// ----------------------------------------------------------------------------
// Flat JSON object scanner package
// Shared types, character codes, event codes and helper functions.
// ----------------------------------------------------------------------------
package fjs_pkg;

    localparam int COUNT_BITS = 16;
    localparam int NUM_W      = 32;

    // Character codes of the grammar.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    localparam logic [NUM_W-1:0] DECIMAL_BASE = NUM_W'(10);

    // Event codes carried on each result word.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_KEY_CHAR = 3'd1;
    localparam logic [2:0] EV_KEY_END  = 3'd2;
    localparam logic [2:0] EV_STR_CHAR = 3'd3;
    localparam logic [2:0] EV_STR_END  = 3'd4;
    localparam logic [2:0] EV_NUM_END  = 3'd5;

    typedef enum logic [3:0] {
        PH_OPEN,
        PH_FIRSTPOS,
        PH_KEYPOS,
        PH_KEYF,
        PH_KEYM,
        PH_COLON,
        PH_VSPACE,
        PH_VSTART,
        PH_STRF,
        PH_STRM,
        PH_NUM,
        PH_AFTVAL,
        PH_AFTCOMMA,
        PH_CLOSED,
        PH_CLOSED_EMPTY,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]              event_res;
        logic [7:0]              char_out;
        logic signed [NUM_W-1:0] number_value;
        logic                    finished;
        logic                    text_valid;
    } t_result;

    function automatic logic is_text_char(input logic [7:0] b);
        return (b >= CH_SPACE) && (b <= CH_TILDE) && (b != CH_QUOTE);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

FILE: src/fjs_if.sv
// ----------------------------------------------------------------------------
// Flat JSON object scanner channels
// Valid/ready channels for text bytes in and scan results out.
// ----------------------------------------------------------------------------
interface fjs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface fjs_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic [7:0]         char_out;
    logic signed [31:0] number_value;
    logic               finished;
    logic               text_valid;

    modport source (
        output valid, output event_res, output char_out, output number_value,
        output finished, output text_valid, input ready
    );
    modport sink (
        input valid, input event_res, input char_out, input number_value,
        input finished, input text_valid, output ready
    );
endinterface

FILE: src/fjs_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one text byte per cycle unless stalled; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module fjs_in_stage
    import fjs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // No word is taken while reset is held.
    assign o_ready = i_rst_n && (!r_valid || i_take);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: src/fjs_scan_core.sv
// ----------------------------------------------------------------------------
// Scan core
// Grammar state machine, pair/comma counters and decimal accumulator.
// ----------------------------------------------------------------------------
module fjs_scan_core
    import fjs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    t_phase                  r_phase, n_phase;
    logic [COUNT_BITS-1:0]   r_pair, n_pair;
    logic [COUNT_BITS-1:0]   r_comma, n_comma;
    logic [NUM_W-1:0]        r_acc, n_acc;
    logic                    r_neg, n_neg;

    logic [7:0]              b;
    logic [7:0]              digit;
    logic [NUM_W-1:0]        digit_ext;
    logic                    b_text;
    logic                    b_digit;
    t_phase                  kp_phase;
    t_phase                  vs_phase;
    logic [NUM_W-1:0]        vs_acc;
    logic                    vs_neg;
    t_phase                  av_phase;
    logic                    av_comma;
    t_phase                  step_phase;
    logic [COUNT_BITS-1:0]   step_pair;
    logic [COUNT_BITS-1:0]   step_comma;
    logic [NUM_W-1:0]        step_acc;
    logic                    step_neg;
    logic [2:0]              ev;
    logic [7:0]              ch;
    logic [NUM_W-1:0]        num;

    assign b         = i_item.text_byte;
    assign digit     = b - CH_ZERO;
    assign digit_ext = {{(NUM_W-8){1'b0}}, digit};
    assign b_text    = is_text_char(b);
    assign b_digit   = is_digit(b);

    // Shared sub-decisions: key position, value start, after a value.
    always_comb begin
        kp_phase = (b == CH_QUOTE)  ? PH_KEYF :
                   (b == CH_RBRACE) ? PH_CLOSED : PH_ERROR;

        vs_acc   = '0;
        vs_neg   = 1'b0;
        vs_phase = PH_ERROR;
        if (b == CH_QUOTE) begin
            vs_phase = PH_STRF;
        end else if (b == CH_MINUS) begin
            vs_phase = PH_NUM;
            vs_neg   = 1'b1;
        end else if (b_digit) begin
            vs_phase = PH_NUM;
            vs_acc   = digit_ext;
        end

        av_comma = (b == CH_COMMA);
        av_phase = av_comma ? PH_AFTCOMMA :
                   (b == CH_SPACE) ? PH_KEYPOS : kp_phase;
    end

    // Next state.
    always_comb begin
        step_phase = r_phase;
        step_pair  = r_pair;
        step_comma = r_comma;
        step_acc   = r_acc;
        step_neg   = r_neg;
        unique case (r_phase)
            PH_OPEN: begin
                step_phase = (b == CH_LBRACE) ? PH_FIRSTPOS : PH_ERROR;
            end
            PH_FIRSTPOS: begin
                step_phase = (b == CH_RBRACE) ? PH_CLOSED_EMPTY :
                             (b == CH_QUOTE)  ? PH_KEYF : PH_ERROR;
            end
            PH_KEYPOS: begin
                step_phase = kp_phase;
            end
            PH_KEYF, PH_KEYM: begin
                if (b_text) begin
                    step_phase = PH_KEYM;
                end else if (b == CH_QUOTE && r_phase == PH_KEYM) begin
                    step_phase = PH_COLON;
                end else begin
                    step_phase = PH_ERROR;
                end
            end
            PH_COLON: begin
                step_phase = (b == CH_COLON) ? PH_VSPACE : PH_ERROR;
            end
            PH_VSPACE, PH_VSTART: begin
                if (b == CH_SPACE && r_phase == PH_VSPACE) begin
                    step_phase = PH_VSTART;
                end else begin
                    step_phase = vs_phase;
                    step_acc   = vs_acc;
                    step_neg   = vs_neg;
                end
            end
            PH_STRF, PH_STRM: begin
                if (b_text) begin
                    step_phase = PH_STRM;
                end else if (b == CH_QUOTE && r_phase == PH_STRM) begin
                    step_phase = PH_AFTVAL;
                    step_pair  = r_pair + CNT_ONE;
                end else begin
                    step_phase = PH_ERROR;
                end
            end
            PH_NUM: begin
                if (b_digit) begin
                    step_acc = r_acc * DECIMAL_BASE + digit_ext;
                end else begin
                    step_pair  = r_pair + CNT_ONE;
                    step_phase = av_phase;
                    if (av_comma) begin
                        step_comma = r_comma + CNT_ONE;
                    end
                end
            end
            PH_AFTVAL: begin
                step_phase = av_phase;
                if (av_comma) begin
                    step_comma = r_comma + CNT_ONE;
                end
            end
            PH_AFTCOMMA: begin
                step_phase = (b == CH_SPACE) ? PH_KEYPOS : kp_phase;
            end
            default: begin
                // Closed object, or an error already seen: any further byte is an error.
                step_phase = PH_ERROR;
            end
        endcase

        // The last byte of a text restarts the scanner.
        if (i_item.last_byte) begin
            n_phase = PH_OPEN;
            n_pair  = '0;
            n_comma = '0;
            n_acc   = '0;
            n_neg   = 1'b0;
        end else begin
            n_phase = step_phase;
            n_pair  = step_pair;
            n_comma = step_comma;
            n_acc   = step_acc;
            n_neg   = step_neg;
        end
    end

    // Result word.
    always_comb begin
        ev  = EV_NONE;
        ch  = '0;
        num = '0;
        unique case (r_phase)
            PH_KEYF, PH_KEYM: begin
                if (b_text) begin
                    ev = EV_KEY_CHAR;
                    ch = b;
                end else if (b == CH_QUOTE && r_phase == PH_KEYM) begin
                    ev = EV_KEY_END;
                end
            end
            PH_STRF, PH_STRM: begin
                if (b_text) begin
                    ev = EV_STR_CHAR;
                    ch = b;
                end else if (b == CH_QUOTE && r_phase == PH_STRM) begin
                    ev = EV_STR_END;
                end
            end
            PH_NUM: begin
                // The byte that ends the digits reports the number even if it is bad.
                if (!b_digit) begin
                    ev  = EV_NUM_END;
                    num = r_neg ? (NUM_W'(0) - r_acc) : r_acc;
                end
            end
            default: begin
                ev = EV_NONE;
            end
        endcase

        o_result.event_res    = ev;
        o_result.char_out     = ch;
        o_result.number_value = num;
        o_result.finished     = i_item.last_byte;
        o_result.text_valid   = i_item.last_byte &&
            ((step_phase == PH_CLOSED_EMPTY) ||
             (step_phase == PH_CLOSED && step_comma == (step_pair - CNT_ONE)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPEN;
            r_pair  <= '0;
            r_comma <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pair  <= n_pair;
            r_comma <= n_comma;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
        end
    end

endmodule

FILE: src/fjs_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module fjs_out_stage
    import fjs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: src/flat_json_object_scanner.sv
// An accepted byte is held in the input register, then loaded into the result
// register, from which its result word is offered.
// Throughput: one byte per cycle unless the consumer stalls; the grammar state,
// counters and the multiply-by-ten accumulate all update in the single cycle a
// byte leaves the input register for the result register.
// Reset: synchronous, active low; the scanner waits for an opening brace,
// both registers are empty and no byte is accepted while reset is held.
// ----------------------------------------------------------------------------
// Flat JSON object scanner
// Checks a byte stream against a flat object grammar and reports keys,
// string values, decoded numbers and a final pass/fail word per text.
// ----------------------------------------------------------------------------
module flat_json_object_scanner
    import fjs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fjs_in_if.sink      i_text,
    fjs_out_if.source   o_result
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_ready;
    logic    fire;
    t_result step_result;
    t_result out_result;

    assign in_item.text_byte = i_text.text_byte;
    assign in_item.last_byte = i_text.last_byte;
    assign fire              = held_valid && out_ready;

    fjs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_text.valid),
        .o_ready (i_text.ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (out_ready),
        .o_item  (held_item)
    );

    fjs_scan_core u_scan_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (step_result)
    );

    fjs_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_ready  (out_ready),
        .i_result (step_result),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (out_result)
    );

    assign o_result.event_res    = out_result.event_res;
    assign o_result.char_out     = out_result.char_out;
    assign o_result.number_value = out_result.number_value;
    assign o_result.finished     = out_result.finished;
    assign o_result.text_valid   = out_result.text_valid;

endmodule

FILE: src/fjs_checker.sv
// ----------------------------------------------------------------------------
// Scanner port checker
// Watches the result channel of the scanner and is bound to its top level.
// ----------------------------------------------------------------------------
module fjs_checker
    import fjs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_event_res,
    input logic [7:0]  i_char_out,
    input logic [31:0] i_number_value,
    input logic        i_finished,
    input logic        i_text_valid
);

    // Only the six defined event codes ever appear.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_res <= EV_NUM_END))
        else $error("undefined event code on result word");

    // Character events carry a printable non-quote character; others carry zero.
    a_char_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (((i_event_res == EV_KEY_CHAR) || (i_event_res == EV_STR_CHAR)) ?
                is_text_char(i_char_out) : (i_char_out == 8'd0)))
        else $error("character field does not match event");

    // A number is reported only with the number end event.
    a_number_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_event_res != EV_NUM_END)) |-> (i_number_value == '0))
        else $error("number field set without number end event");

    // A pass flag is only given on the final word of a text.
    a_valid_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_finished) |-> !i_text_valid)
        else $error("text_valid set on a word that is not final");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_event_res) && $stable(i_char_out) &&
             $stable(i_number_value) && $stable(i_finished) && $stable(i_text_valid)))
        else $error("result word changed while stalled");

endmodule

bind flat_json_object_scanner fjs_checker u_fjs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_event_res    (o_result.event_res),
    .i_char_out     (o_result.char_out),
    .i_number_value (o_result.number_value),
    .i_finished     (o_result.finished),
    .i_text_valid   (o_result.text_valid)
);
